FILE: hdl/lra_pkg.sv
package lra_pkg;

	localparam int CHAN_BITS = 8;
	localparam int STR_BITS  = 10;
	localparam int CFG_BITS  = 13;
	localparam int APB_BITS  = 32;
	localparam int ADDR_BITS = 3;

	localparam logic [STR_BITS-1:0] STR_MAX      = 10'd255;
	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	// register select is paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} rgb_t;

	// exact floor(p / 255) for any 16-bit p below 65280, so for every 8x8 product
	function automatic logic [CHAN_BITS-1:0] div255(input logic [2*CHAN_BITS-1:0] p);
		logic [2*CHAN_BITS:0] t;
		t = {1'b0, p} + 17'(p[2*CHAN_BITS-1:CHAN_BITS]) + 17'd1;
		return t[2*CHAN_BITS-1:CHAN_BITS];
	endfunction

endpackage

FILE: hdl/line_rasterizer_additive.sv
// channel   dir  handshake         payload
// s_*       in   s_tvalid/s_tready kind in tuser; endpoints, color, strength in tdata
// m_*       out  m_tvalid/m_tready pixel in tdata; end point in tlast
// apb       in   psel/penable      frame_width at 0x0, frame_height at 0x4
// One request per clock unless m_tready stalls; each passes input, then output register.
// Each advance makes one Bresenham step, each start emits its start point, in a single pass
// between the input register and the output register; the 8x8 color scaling runs alongside.
// m_tready low stalls the output register; the input register then fills
// and s_tready drops. Reset clears both valid flags and the busy flag.
module line_rasterizer_additive #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// start_x, start_y, finish_x, finish_y, blue_in, green_in, red_in, strength, zero pad
	input  logic [((4*COORD_BITS+34+7)/8)*8-1:0] s_tdata,
	// kind
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_x, pixel_y, in-frame flag, blue addend, green addend, red addend, zero pad
	output logic [((2*COORD_BITS+25+7)/8)*8-1:0] m_tdata,
	// last_pixel
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lra_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [lra_pkg::APB_BITS-1:0]        pwdata,
	output logic [lra_pkg::APB_BITS-1:0]        prdata,
	output logic                                pready
);
	import lra_pkg::*;

	localparam int CB       = COORD_BITS;
	localparam int OUT_BITS = ((2*COORD_BITS+25+7)/8)*8;
	localparam int SX0 = 0;
	localparam int SY0 = CB;
	localparam int FX0 = 2*CB;
	localparam int FY0 = 3*CB;
	localparam int B0  = 4*CB;
	localparam int G0  = 4*CB + 8;
	localparam int R0  = 4*CB + 16;
	localparam int S0  = 4*CB + 24;

	logic [CFG_BITS-1:0] width_q, height_q;

	logic                s1_valid;
	logic                kind_s1;
	logic [CB-1:0]       sx_s1, sy_s1, fx_s1, fy_s1;
	rgb_t                color_s1;
	logic [STR_BITS-1:0] str_s1;

	logic                m_valid_s2;
	logic [CB-1:0]       x_s2, y_s2;
	logic                inside_s2, last_s2;
	rgb_t                add_s2;

	logic    out_free, take;
	rgb_t    addend_in, addend_out;
	logic    res_valid, in_frame, last;
	logic [CB-1:0] pix_x, pix_y;

	assign pready   = 1'b1;
	assign out_free = !m_valid_s2 || m_tready;
	assign take     = s1_valid && out_free;
	assign s_tready = !s1_valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_BITS-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[CFG_BITS-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = APB_BITS'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_BITS'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1        <= s_tuser;
			sx_s1          <= s_tdata[SX0 +: CB];
			sy_s1          <= s_tdata[SY0 +: CB];
			fx_s1          <= s_tdata[FX0 +: CB];
			fy_s1          <= s_tdata[FY0 +: CB];
			color_s1.blue  <= s_tdata[B0 +: CHAN_BITS];
			color_s1.green <= s_tdata[G0 +: CHAN_BITS];
			color_s1.red   <= s_tdata[R0 +: CHAN_BITS];
			str_s1         <= s_tdata[S0 +: STR_BITS];
		end
	end

	lra_scale u_scale (
		.color    (color_s1),
		.strength (str_s1),
		.addend   (addend_in)
	);

	lra_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.kind         (kind_s1),
		.start_x      (sx_s1),
		.start_y      (sy_s1),
		.finish_x     (fx_s1),
		.finish_y     (fy_s1),
		.addend_in    (addend_in),
		.frame_width  (width_q),
		.frame_height (height_q),
		.res_valid    (res_valid),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.in_frame     (in_frame),
		.addend_out   (addend_out),
		.last         (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (take) begin
			m_valid_s2 <= res_valid;
		end else if (m_tready) begin
			m_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s2      <= pix_x;
			y_s2      <= pix_y;
			inside_s2 <= in_frame;
			add_s2    <= addend_out;
			last_s2   <= last;
		end
	end

	assign m_tvalid = m_valid_s2;
	assign m_tdata  = OUT_BITS'({add_s2.red, add_s2.green, add_s2.blue, inside_s2, y_s2, x_s2});
	assign m_tlast  = last_s2;

endmodule

FILE: hdl/lra_scale.sv
module lra_scale (
	input  lra_pkg::rgb_t                  color,
	input  logic [lra_pkg::STR_BITS-1:0]   strength,
	output lra_pkg::rgb_t                  addend
);
	import lra_pkg::*;

	logic [CHAN_BITS-1:0]   level;
	logic [2*CHAN_BITS-1:0] prod_b;
	logic [2*CHAN_BITS-1:0] prod_g;
	logic [2*CHAN_BITS-1:0] prod_r;

	always_comb begin
		level  = (strength > STR_MAX) ? STR_MAX[CHAN_BITS-1:0] : strength[CHAN_BITS-1:0];
		prod_b = color.blue * level;
		prod_g = color.green * level;
		prod_r = color.red * level;
		addend.blue  = div255(prod_b);
		addend.green = div255(prod_g);
		addend.red   = div255(prod_r);
	end

endmodule

FILE: hdl/lra_core.sv
module lra_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic                          kind,
	input  logic [COORD_BITS-1:0]         start_x,
	input  logic [COORD_BITS-1:0]         start_y,
	input  logic [COORD_BITS-1:0]         finish_x,
	input  logic [COORD_BITS-1:0]         finish_y,
	input  lra_pkg::rgb_t                 addend_in,
	input  logic [lra_pkg::CFG_BITS-1:0]  frame_width,
	input  logic [lra_pkg::CFG_BITS-1:0]  frame_height,
	output logic                          res_valid,
	output logic [COORD_BITS-1:0]         pix_x,
	output logic [COORD_BITS-1:0]         pix_y,
	output logic                          in_frame,
	output lra_pkg::rgb_t                 addend_out,
	output logic                          last
);
	import lra_pkg::*;

	localparam int SW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	logic                  busy_q;
	logic [COORD_BITS-1:0] col_q, row_q, goal_col_q, goal_row_q;
	logic [SW-1:0]         span_x_q, span_y_q;
	logic                  dir_x_neg_q, dir_y_neg_q;
	logic [EW-1:0]         err_q;
	rgb_t                  addend_q;

	logic [SW-1:0]         dx, dy, sx_st, sy_st;
	logic                  dxn_st, dyn_st;
	logic [EW-1:0]         err_st;
	logic [EW:0]           twice, neg_sy, pos_sx;
	logic                  move_x, move_y;
	logic [EW-1:0]         err_stp;
	logic [COORD_BITS-1:0] col_stp, row_stp;
	logic [COORD_BITS-1:0] col_nx, row_nx, goal_col_nx, goal_row_nx;
	logic                  start;

	always_comb begin
		start = (kind == KIND_START);

		dx     = {finish_x[COORD_BITS-1], finish_x} - {start_x[COORD_BITS-1], start_x};
		dy     = {finish_y[COORD_BITS-1], finish_y} - {start_y[COORD_BITS-1], start_y};
		sx_st  = dx[SW-1] ? (~dx + SW'(1)) : dx;
		sy_st  = dy[SW-1] ? (~dy + SW'(1)) : dy;
		dxn_st = dx[SW-1] | (dx == '0);
		dyn_st = dy[SW-1] | (dy == '0);
		err_st = {2'b00, sx_st} - {2'b00, sy_st};

		twice  = {err_q, 1'b0};
		neg_sy = ~{3'b000, span_y_q} + (EW+1)'(1);
		pos_sx = {3'b000, span_x_q};
		move_x = $signed(twice) > $signed(neg_sy);
		move_y = $signed(twice) < $signed(pos_sx);
		err_stp = err_q - (move_x ? {2'b00, span_y_q} : '0)
		                + (move_y ? {2'b00, span_x_q} : '0);
		col_stp = move_x ? (col_q + (dir_x_neg_q ? '1 : COORD_BITS'(1))) : col_q;
		row_stp = move_y ? (row_q + (dir_y_neg_q ? '1 : COORD_BITS'(1))) : row_q;

		col_nx      = start ? start_x  : col_stp;
		row_nx      = start ? start_y  : row_stp;
		goal_col_nx = start ? finish_x : goal_col_q;
		goal_row_nx = start ? finish_y : goal_row_q;

		last       = (col_nx == goal_col_nx) && (row_nx == goal_row_nx);
		res_valid  = start || busy_q;
		pix_x      = col_nx;
		pix_y      = row_nx;
		addend_out = start ? addend_in : addend_q;
		in_frame   = !col_nx[COORD_BITS-1] && !row_nx[COORD_BITS-1]
		          && ({{CFG_BITS{1'b0}}, col_nx} < {{COORD_BITS{1'b0}}, frame_width})
		          && ({{CFG_BITS{1'b0}}, row_nx} < {{COORD_BITS{1'b0}}, frame_height});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take && res_valid) begin
			busy_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && start) begin
			col_q       <= start_x;
			row_q       <= start_y;
			goal_col_q  <= finish_x;
			goal_row_q  <= finish_y;
			span_x_q    <= sx_st;
			span_y_q    <= sy_st;
			dir_x_neg_q <= dxn_st;
			dir_y_neg_q <= dyn_st;
			err_q       <= err_st;
			addend_q    <= addend_in;
		end else if (take && busy_q) begin
			col_q <= col_stp;
			row_q <= row_stp;
			err_q <= err_stp;
		end
	end

endmodule
